// File: design/mssa_pkg.sv
`default_nettype none

package mssa_pkg;

    // Field widths of the item channels and the configuration register.
    localparam int MODE_W   = 2;
    localparam int INDEX_W  = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;
    localparam int CFG_W    = 4;

    // Operation codes.
    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd3;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_valid;
    } t_stat;

endpackage

`default_nettype wire

// File: design/mssa_in_if.sv
`default_nettype none

interface mssa_in_if;
    logic                                    valid;
    logic                                    ready;
    logic        [mssa_pkg::MODE_W-1:0]      mode;
    logic        [mssa_pkg::INDEX_W-1:0]     stack_index;
    logic signed [mssa_pkg::DATA_W-1:0]      push_value;

    modport source (output valid, output mode, output stack_index, output push_value,
                    input ready);
    modport sink   (input valid, input mode, input stack_index, input push_value,
                    output ready);
endinterface

`default_nettype wire

// File: design/mssa_out_if.sv
`default_nettype none

interface mssa_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [mssa_pkg::DATA_W-1:0]      data_out;
    logic        [mssa_pkg::STATUS_W-1:0]    status;
    logic        [mssa_pkg::FILL_W-1:0]      fill_count;

    modport source (output valid, output data_out, output status, output fill_count,
                    input ready);
    modport sink   (input valid, input data_out, input status, input fill_count,
                    output ready);
endinterface

`default_nettype wire

// File: design/mssa_ram.sv
`default_nettype none

module mssa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/mssa_ctrl.sv
`default_nettype none

module mssa_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_out_ready,
    input  wire mssa_pkg::t_stat i_stat,
    output logic                 o_in_ready,
    output mssa_pkg::t_cmd       o_cmd
);

    mssa_pkg::t_state r_state;
    mssa_pkg::t_state n_state;
    logic             w_out_free;

    // The output register can take a new result when empty or being drained.
    assign w_out_free = !i_stat.out_valid || i_out_ready;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mssa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mssa_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = mssa_pkg::S_EXEC;
                end
            end
            mssa_pkg::S_EXEC: begin
                n_state = mssa_pkg::S_LOAD;
            end
            mssa_pkg::S_LOAD: begin
                if (w_out_free) begin
                    n_state = mssa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mssa_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.exec    = 1'b0;
        o_cmd.load    = 1'b0;
        case (r_state)
            mssa_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            mssa_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            mssa_pkg::S_LOAD: begin
                o_cmd.load = w_out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/mssa_dp.sv
`default_nettype none

module mssa_dp #(
    parameter int DEPTH      = 16,
    parameter int MAX_STACKS = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [mssa_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire mssa_pkg::t_cmd                    i_cmd,
    input  wire logic [mssa_pkg::MODE_W-1:0]       i_mode,
    input  wire logic [mssa_pkg::INDEX_W-1:0]      i_stack_index,
    input  wire logic [mssa_pkg::DATA_W-1:0]       i_push_value,
    input  wire logic                              i_out_ready,
    output mssa_pkg::t_stat                        o_stat,
    output logic                                   o_out_valid,
    output logic      [mssa_pkg::DATA_W-1:0]       o_data_out,
    output logic      [mssa_pkg::STATUS_W-1:0]     o_status,
    output logic      [mssa_pkg::FILL_W-1:0]       o_fill_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int KW = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
    localparam int CW = mssa_pkg::CFG_W;
    localparam int BW = FW + mssa_pkg::INDEX_W;
    localparam int PW = FW + CW;

    // Segment size for each stack count a 4-bit register can name.
    localparam logic [FW-1:0] SEG_TAB [16] = '{
        FW'(DEPTH),      FW'(DEPTH / 1),  FW'(DEPTH / 2),  FW'(DEPTH / 3),
        FW'(DEPTH / 4),  FW'(DEPTH / 5),  FW'(DEPTH / 6),  FW'(DEPTH / 7),
        FW'(DEPTH / 8),  FW'(DEPTH / 9),  FW'(DEPTH / 10), FW'(DEPTH / 11),
        FW'(DEPTH / 12), FW'(DEPTH / 13), FW'(DEPTH / 14), FW'(DEPTH / 15)
    };

    // Configuration state.
    logic [CW-1:0] r_num;
    logic [FW-1:0] r_seg;
    logic [FW-1:0] r_last_cap;
    logic [FW-1:0] r_fill [MAX_STACKS];

    // Captured item.
    logic [mssa_pkg::MODE_W-1:0]  r_mode;
    logic [mssa_pkg::INDEX_W-1:0] r_k;
    logic [mssa_pkg::DATA_W-1:0]  r_val;

    // Result of the execute step.
    logic                          r_rd;
    logic [mssa_pkg::STATUS_W-1:0] r_res_status;
    logic [mssa_pkg::FILL_W-1:0]   r_res_fill;

    // Output register.
    logic                          r_out_valid;
    logic [mssa_pkg::DATA_W-1:0]   r_out_data;
    logic [mssa_pkg::STATUS_W-1:0] r_out_status;
    logic [mssa_pkg::FILL_W-1:0]   r_out_fill;

    logic [CW-1:0]                 w_cfg_n;
    logic [FW-1:0]                 w_cfg_seg;
    logic [PW-1:0]                 w_cfg_used;
    logic [FW-1:0]                 w_cfg_last;

    logic [KW-1:0]                 w_idx;
    logic [CW-1:0]                 w_k_ext;
    logic                          w_bad;
    logic [FW-1:0]                 w_fill;
    logic [FW-1:0]                 w_cap;
    logic [BW-1:0]                 w_base;
    logic [AW-1:0]                 w_push_addr;
    logic [AW-1:0]                 w_top_addr;
    logic                          w_wr;
    logic                          w_rd;
    logic                          w_upd;
    logic [FW-1:0]                 w_new_fill;
    logic [mssa_pkg::STATUS_W-1:0] w_status;
    logic [FW-1:0]                 w_res_fill;
    logic [mssa_pkg::DATA_W-1:0]   w_rd_data;

    // Clamp the written stack count and derive the segment sizes.
    always_comb begin
        w_cfg_n = i_cfg_data;
        if (w_cfg_n == '0) begin
            w_cfg_n = CW'(1);
        end else if (int'(w_cfg_n) > MAX_STACKS) begin
            w_cfg_n = CW'(MAX_STACKS);
        end
        w_cfg_seg  = SEG_TAB[w_cfg_n];
        w_cfg_used = PW'(w_cfg_n - CW'(1)) * PW'(w_cfg_seg);
        w_cfg_last = FW'(PW'(DEPTH) - w_cfg_used);
    end

    // Address the stack and decide the operation.
    always_comb begin
        w_idx       = KW'(r_k);
        w_k_ext     = CW'(r_k);
        w_bad       = (w_k_ext >= r_num);
        w_fill      = r_fill[w_idx];
        w_cap       = ((w_k_ext + CW'(1)) < r_num) ? r_seg : r_last_cap;
        w_base      = BW'(r_k) * BW'(r_seg);
        w_push_addr = AW'(w_base + BW'(w_fill));
        w_top_addr  = AW'(w_base + BW'(w_fill) - BW'(1));
        w_wr        = 1'b0;
        w_rd        = 1'b0;
        w_upd       = 1'b0;
        w_new_fill  = w_fill;
        w_status    = mssa_pkg::ST_OK;
        w_res_fill  = w_fill;
        if (w_bad) begin
            w_status   = mssa_pkg::ST_BADIDX;
            w_res_fill = '0;
        end else begin
            case (r_mode)
                mssa_pkg::MODE_PUSH: begin
                    if (w_fill >= w_cap) begin
                        w_status = mssa_pkg::ST_FULL;
                    end else begin
                        w_wr       = 1'b1;
                        w_upd      = 1'b1;
                        w_new_fill = w_fill + FW'(1);
                        w_res_fill = w_new_fill;
                    end
                end
                mssa_pkg::MODE_POP, mssa_pkg::MODE_PEEK: begin
                    if (w_fill == '0) begin
                        w_status = mssa_pkg::ST_EMPTY;
                    end else begin
                        w_rd = 1'b1;
                        if (r_mode == mssa_pkg::MODE_POP) begin
                            w_upd      = 1'b1;
                            w_new_fill = w_fill - FW'(1);
                            w_res_fill = w_new_fill;
                        end
                    end
                end
                default: begin
                    w_status = mssa_pkg::ST_OK;
                end
            endcase
        end
    end

    // Shared word store.
    mssa_ram #(
        .WIDTH (mssa_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.exec && w_wr),
        .i_wr_addr (w_push_addr),
        .i_wr_data (r_val),
        .i_rd_en   (i_cmd.exec && w_rd),
        .i_rd_addr (w_top_addr),
        .o_rd_data (w_rd_data)
    );

    // Configuration and fill counts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num      <= CW'(1);
            r_seg      <= FW'(DEPTH);
            r_last_cap <= FW'(DEPTH);
            for (int i = 0; i < MAX_STACKS; i++) begin
                r_fill[i] <= '0;
            end
        end else if (i_cfg_we) begin
            r_num      <= w_cfg_n;
            r_seg      <= w_cfg_seg;
            r_last_cap <= w_cfg_last;
            for (int i = 0; i < MAX_STACKS; i++) begin
                r_fill[i] <= '0;
            end
        end else if (i_cmd.exec && w_upd) begin
            r_fill[w_idx] <= w_new_fill;
        end
    end

    // Item capture and execute results.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_k    <= i_stack_index;
            r_val  <= i_push_value;
        end
        if (i_cmd.exec) begin
            r_rd         <= w_rd;
            r_res_status <= w_status;
            r_res_fill   <= mssa_pkg::FILL_W'(w_res_fill);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_data   <= r_rd ? w_rd_data : '0;
            r_out_status <= r_res_status;
            r_out_fill   <= r_res_fill;
        end
    end

    assign o_stat.out_valid = r_out_valid;
    assign o_out_valid      = r_out_valid;
    assign o_data_out       = r_out_data;
    assign o_status         = r_out_status;
    assign o_fill_count     = r_out_fill;

endmodule

`default_nettype wire

// File: design/multi_stack_shared_array_core.sv
// Several LIFO stacks sharing one word store of DEPTH words.
// Input channel i_in carries one item per operation: mode (push, pop, peek),
// stack_index and push_value. Output channel o_out returns exactly one result
// item per input item: data_out, status and fill_count of the addressed stack.
// i_cfg_we with i_cfg_data writes the stack count; a write recomputes the
// segment sizes from a constant table and empties every stack. Write it only
// while no item is in flight.
// An item passes through capture, execute (fill count lookup, address
// multiply and add, one store access), then load of the output register
// after the registered store read. The block takes no new item on i_in
// until the current one has been loaded into the output register.
// The output register holds a finished result while the next item is
// accepted; a stall on o_out that lasts until the next item reaches its
// load step holds the block there and keeps i_in.ready low until the
// result is taken.
// Synchronous active-low reset empties all stacks, sets one stack of DEPTH
// words and clears the output valid. Stored words are not cleared.
`default_nettype none

module multi_stack_shared_array_core #(
    parameter int DEPTH      = 16,
    parameter int MAX_STACKS = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [mssa_pkg::CFG_W-1:0] i_cfg_data,
    mssa_in_if.sink                         i_in,
    mssa_out_if.source                      o_out
);

    mssa_pkg::t_cmd  w_cmd;
    mssa_pkg::t_stat w_stat;

    // Controller.
    mssa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_in_ready  (i_in.ready),
        .o_cmd       (w_cmd)
    );

    // Datapath.
    mssa_dp #(
        .DEPTH      (DEPTH),
        .MAX_STACKS (MAX_STACKS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (w_cmd),
        .i_mode        (i_in.mode),
        .i_stack_index (i_in.stack_index),
        .i_push_value  (i_in.push_value),
        .i_out_ready   (o_out.ready),
        .o_stat        (w_stat),
        .o_out_valid   (o_out.valid),
        .o_data_out    (o_out.data_out),
        .o_status      (o_out.status),
        .o_fill_count  (o_out.fill_count)
    );

`ifndef ASSERT_OFF
    // After an item is accepted the block is busy with it.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted while an item was in execution");

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> (!o_out.valid || o_out.ready))
        else $error("output register overwritten");

    // A bad index or an empty stack reports no data and no entries.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == mssa_pkg::ST_BADIDX ||
                         o_out.status == mssa_pkg::ST_EMPTY))
        |-> (o_out.data_out == '0 && o_out.fill_count == '0))
        else $error("error result carries data or a fill count");

    // A result is loaded once its item has passed execute, unless o_out stalls.
    a_load_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> ##1 w_cmd.load || !(!o_out.valid || o_out.ready))
        else $error("result not loaded after execute");
`endif

endmodule

`default_nettype wire
